### src/cfse_pkg.sv
// Shared types, constants and the field extraction function of the CAN signal extractor.
package cfse_pkg;

  // Default number of descriptor slots.
  localparam int SLOT_COUNT_DEF = 16;
  // Most results given for one frame.
  localparam int MAX_RESULTS = 16;
  localparam int RES_W = $clog2(MAX_RESULTS + 1);
  // Widest multi-byte signal, in bytes.
  localparam int MAX_JOIN_BYTES = 4;
  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Input action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  // Queued item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // One descriptor slot.
  typedef struct packed {
    logic        valid;
    logic [28:0] frame_id;
    logic [3:0]  signal_number;
    logic [2:0]  byte_high;
    logic [2:0]  byte_low;
    logic [2:0]  bit_high;
    logic [2:0]  bit_low;
  } desc_t;

  // One classified item on its way from front to back.
  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    desc_t       desc;
    logic [63:0] data;
  } item_t;

  // Pull one signal out of the eight data bytes as the descriptor describes it.
  function automatic logic [31:0] extract_value(desc_t d, logic [63:0] data);
    logic [63:0] shifted;
    logic [7:0]  b;
    logic [2:0]  span;
    logic [2:0]  width_m1;
    logic [7:0]  field;
    logic [7:0]  mask8;
    logic [31:0] value;
    shifted  = data >> {d.byte_low, 3'b000};
    b        = shifted[7:0];
    span     = d.byte_high - d.byte_low;
    width_m1 = d.bit_high - d.bit_low;
    field    = b >> d.bit_low;
    mask8    = 8'hFF >> (3'd7 - width_m1);
    value    = '0;
    if (d.byte_high != d.byte_low) begin
      // Joined bytes: reversed or too wide gives zero.
      if (d.byte_high > d.byte_low && {1'b0, span} < 4'(MAX_JOIN_BYTES)) begin
        unique case (span)
          3'd1:    value = {16'h0000, shifted[15:0]};
          3'd2:    value = {8'h00, shifted[23:0]};
          default: value = shifted[31:0];
        endcase
      end
    end else if (d.bit_high == 3'd0 && d.bit_low == 3'd0) begin
      value = {24'h000000, b};
    end else if (d.bit_high >= d.bit_low) begin
      value = {24'h000000, field & mask8};
    end
    return value;
  endfunction

endpackage

### src/cfse_front.sv
// Front end: accepts input beats and classifies them into queue items.
module cfse_front import cfse_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [3:0]  in_slot,
  input  logic        in_slot_valid,
  input  logic [3:0]  in_signal_number,
  input  logic [28:0] in_frame_id,
  input  logic [2:0]  in_byte_high,
  input  logic [2:0]  in_byte_low,
  input  logic [2:0]  in_bit_high,
  input  logic [2:0]  in_bit_low,
  input  logic [63:0] in_frame_data,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic [6:0] slot_ext;
  logic       drop;

  // A write to a slot beyond the table is taken and discarded.
  assign slot_ext = {3'b000, in_slot};
  assign drop     = (in_action == ACT_WRITE) && (slot_ext >= 7'(SLOT_COUNT));
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && !drop;

  // Build the item; clearing a slot stores an all-zero descriptor.
  always_comb begin
    q_item      = '0;
    q_item.slot = in_slot;
    if (in_action == ACT_FRAME) begin
      q_item.kind          = KIND_FRAME;
      q_item.desc.frame_id = in_frame_id;
      q_item.data          = in_frame_data;
    end else begin
      q_item.kind = KIND_WRITE;
      if (in_slot_valid) begin
        q_item.desc.valid         = 1'b1;
        q_item.desc.frame_id      = in_frame_id;
        q_item.desc.signal_number = in_signal_number;
        q_item.desc.byte_high     = in_byte_high;
        q_item.desc.byte_low      = in_byte_low;
        q_item.desc.bit_high      = in_bit_high;
        q_item.desc.bit_low       = in_bit_low;
      end
    end
  end

endmodule

### src/cfse_queue.sv
// Short item queue between the front end and the slot scanner.
module cfse_queue import cfse_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/cfse_back.sv
// Back end: descriptor table, slot scanner and result output register.
module cfse_back import cfse_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_signal_id,
  output logic [31:0] out_signal_value,
  output logic        out_hit,
  output logic        out_last
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  desc_t             mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              vbit_r;
  desc_t             rdata_r;
  logic [28:0]       fid_r, fid_nxt;
  logic [63:0]       fdata_r, fdata_nxt;
  logic              pend_r, pend_nxt;
  logic [3:0]        pend_id_r, pend_id_nxt;
  logic [31:0]       pend_val_r, pend_val_nxt;
  logic [RES_W-1:0]  n_r, n_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_id_r, out_id_nxt;
  logic [31:0]       out_val_r, out_val_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic              out_last_r, out_last_nxt;

  logic              can_emit, match, hold, issue, tbl_we;
  logic              emit, emit_last, emit_hit;
  logic [3:0]        emit_id;
  logic [31:0]       emit_val;
  logic [31:0]       cur_val;
  logic [6:0]        widx_ext;
  logic [IDX_W-1:0]  widx;
  logic [IDX_W-1:0]  ridx;

  assign widx_ext = {3'b000, q_item.slot};
  assign widx     = widx_ext[IDX_W-1:0];
  assign ridx     = addr_r[IDX_W-1:0];

  // Match test and value for the slot whose read data is present.
  assign can_emit = !out_valid_r || !out_stall;
  assign match    = rd_vld_r && vbit_r && (rdata_r.frame_id == fid_r);
  assign cur_val  = extract_value(rdata_r, fdata_r);
  assign hold     = match && pend_r && !can_emit;
  assign issue    = (state_r == ST_SCAN) && !hold && (addr_r < CNT_W'(SLOT_COUNT));

  // Sequencer: a match is held back until the next one or the end of the scan,
  // so that the final result of a frame can carry its last flag.
  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    rd_vld_nxt   = rd_vld_r;
    fid_nxt      = fid_r;
    fdata_nxt    = fdata_r;
    pend_nxt     = pend_r;
    pend_id_nxt  = pend_id_r;
    pend_val_nxt = pend_val_r;
    n_nxt        = n_r;
    q_pop        = 1'b0;
    tbl_we       = 1'b0;
    emit         = 1'b0;
    emit_last    = 1'b0;
    emit_hit     = 1'b1;
    emit_id      = pend_id_r;
    emit_val     = pend_val_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == KIND_FRAME) begin
            fid_nxt    = q_item.desc.frame_id;
            fdata_nxt  = q_item.data;
            addr_nxt   = '0;
            rd_vld_nxt = 1'b0;
            pend_nxt   = 1'b0;
            n_nxt      = '0;
            state_nxt  = ST_SCAN;
          end else begin
            tbl_we = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!hold) begin
          rd_vld_nxt = issue;
          if (issue) begin
            addr_nxt = addr_r + 1'b1;
          end
          if (rd_vld_r && addr_r == CNT_W'(SLOT_COUNT)) begin
            state_nxt = ST_FLUSH;
          end
          if (match) begin
            emit         = pend_r;
            pend_nxt     = 1'b1;
            pend_id_nxt  = rdata_r.signal_number;
            pend_val_nxt = cur_val;
            n_nxt        = n_r + 1'b1;
            if (n_r == RES_W'(MAX_RESULTS - 1)) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (!pend_r) begin
            emit_hit = 1'b0;
            emit_id  = '0;
            emit_val = '0;
          end
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: loads a new beat or empties once the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_val_nxt   = out_val_r;
    out_hit_nxt   = out_hit_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = emit_id;
      out_val_nxt   = emit_val;
      out_hit_nxt   = emit_hit;
      out_last_nxt  = emit_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      vbit_r      <= 1'b0;
      pend_r      <= 1'b0;
      n_r         <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      pend_r      <= pend_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      if (issue) begin
        vbit_r <= vld_r[ridx];
      end
      if (tbl_we) begin
        vld_r[widx] <= q_item.desc.valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fid_r      <= fid_nxt;
    fdata_r    <= fdata_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_val_r <= pend_val_nxt;
    out_id_r   <= out_id_nxt;
    out_val_r  <= out_val_nxt;
    out_hit_r  <= out_hit_nxt;
    out_last_r <= out_last_nxt;
  end

  // Descriptor table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem_q[widx] <= q_item.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= mem_q[ridx];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_signal_id    = out_id_r;
  assign out_signal_value = out_val_r;
  assign out_hit          = out_hit_r;
  assign out_last         = out_last_r;

endmodule

### src/can_frame_signal_extractor_core.sv
// A descriptor beat passes through the queue and is written to the table once the back end is idle.
// A frame beat is scanned one slot per cycle, unless a match waits on a stalled output register.
// The queue takes new beats during a scan; the back end takes the next item when the scan ends.
// Reset: synchronous, active low; every slot becomes invalid, queue and output empty.
// Top level of the CAN frame signal extractor.
module can_frame_signal_extractor_core import cfse_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [3:0]  in_slot,
  input  logic        in_slot_valid,
  input  logic [3:0]  in_signal_number,
  input  logic [28:0] in_frame_id,
  input  logic [2:0]  in_byte_high,
  input  logic [2:0]  in_byte_low,
  input  logic [2:0]  in_bit_high,
  input  logic [2:0]  in_bit_low,
  input  logic [63:0] in_frame_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_signal_id,
  output logic [31:0] out_signal_value,
  output logic        out_hit,
  output logic        out_last
);

  logic  q_full, q_push, q_pop, q_valid;
  item_t push_item, pop_item;

  // Front end: classification.
  cfse_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_slot         (in_slot),
    .in_slot_valid   (in_slot_valid),
    .in_signal_number(in_signal_number),
    .in_frame_id     (in_frame_id),
    .in_byte_high    (in_byte_high),
    .in_byte_low     (in_byte_low),
    .in_bit_high     (in_bit_high),
    .in_bit_low      (in_bit_low),
    .in_frame_data   (in_frame_data),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  // Decoupling queue.
  cfse_queue #(.DEPTH(QUEUE_DEPTH_DEF)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_item (pop_item)
  );

  // Back end: table and scanner.
  cfse_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_signal_id   (out_signal_id),
    .out_signal_value(out_signal_value),
    .out_hit         (out_hit),
    .out_last        (out_last)
  );

endmodule

### src/cfse_checker.sv
// Port-level checker for the CAN signal extractor, bound to the top level.
module cfse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_signal_id,
  input logic [31:0] out_signal_value,
  input logic        out_hit,
  input logic        out_last
);

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_signal_id) &&
      $stable(out_signal_value) && $stable(out_hit) && $stable(out_last))
    else $error("result beat changed while stalled");

  // A frame without a match gives a single all-zero beat that closes the frame.
  a_miss_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_last && out_signal_id == 4'd0 &&
      out_signal_value == 32'd0)
    else $error("miss beat malformed");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Reset empties the queue, so the input is open right after it.
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind can_frame_signal_extractor_core cfse_checker u_cfse_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_signal_id   (out_signal_id),
  .out_signal_value(out_signal_value),
  .out_hit         (out_hit),
  .out_last        (out_last)
);

### tb/can_frame_signal_extractor_checker.sv
// Channel monitor, signal predictor and result comparison for the CAN signal extractor.
module can_frame_signal_extractor_checker import cfse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [3:0]  in_slot,
  input  logic        in_slot_valid,
  input  logic [3:0]  in_signal_number,
  input  logic [28:0] in_frame_id,
  input  logic [2:0]  in_byte_high,
  input  logic [2:0]  in_byte_low,
  input  logic [2:0]  in_bit_high,
  input  logic [2:0]  in_bit_low,
  input  logic [63:0] in_frame_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_signal_id,
  input  logic [31:0] out_signal_value,
  input  logic        out_hit,
  input  logic        out_last,
  output int          mismatches,
  output int          pending_results
);

  localparam int SLOTS = SLOT_COUNT_DEF;

  // Our own copy of one descriptor slot.
  typedef struct packed {
    logic        valid;
    logic [28:0] can_id;
    logic [3:0]  sig_num;
    logic [2:0]  byte_hi;
    logic [2:0]  byte_lo;
    logic [2:0]  bit_hi;
    logic [2:0]  bit_lo;
  } slot_desc_t;

  // One expected result beat.
  typedef struct packed {
    logic [3:0]  sig_id;
    logic [31:0] value;
    logic        hit;
    logic        last;
  } signal_result_t;

  slot_desc_t     slot_table [SLOTS];
  signal_result_t expected_signals [$];

  // Value of one signal field as the descriptor places it in the data bytes.
  function automatic logic [31:0] signal_field_value(slot_desc_t d, logic [63:0] data);
    logic [31:0] v;
    logic [7:0]  b;
    int          hi;
    int          lo;
    int          width;
    hi = d.byte_hi;
    lo = d.byte_lo;
    v  = '0;
    b  = data[8*lo +: 8];
    if (hi != lo) begin
      // Joined bytes, high byte most significant; reversed or too wide stays zero.
      if (hi > lo && hi - lo + 1 <= MAX_JOIN_BYTES) begin
        for (int i = hi; i >= lo; i--) begin
          v = {v[23:0], data[8*i +: 8]};
        end
      end
    end else if (d.bit_hi == 3'd0 && d.bit_lo == 3'd0) begin
      v = {24'h000000, b};
    end else if (d.bit_hi >= d.bit_lo) begin
      width = int'(d.bit_hi) - int'(d.bit_lo) + 1;
      v = ({24'h000000, b} >> d.bit_lo) & ((32'd1 << width) - 32'd1);
    end
    return v;
  endfunction

  // Queue the results one frame beat should give, in slot order.
  task automatic predict_frame(logic [28:0] id, logic [63:0] data);
    signal_result_t r;
    int             hits;
    hits = 0;
    for (int s = 0; s < SLOTS && hits < MAX_RESULTS; s++) begin
      if (slot_table[s].valid && slot_table[s].can_id == id) begin
        r.sig_id = slot_table[s].sig_num;
        r.value  = signal_field_value(slot_table[s], data);
        r.hit    = 1'b1;
        r.last   = 1'b0;
        expected_signals.push_back(r);
        hits++;
      end
    end
    if (hits == 0) begin
      r      = '0;
      r.last = 1'b1;
      expected_signals.push_back(r);
    end else begin
      expected_signals[expected_signals.size() - 1].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Sample both channels at each rising edge; results are checked before new
  // input beats are predicted.
  always @(posedge clk) begin : watch
    signal_result_t want;
    slot_desc_t     d;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_table[s] = '0;
      end
      expected_signals.delete();
    end else begin
      // Result side: compare against the oldest expectation.
      if (out_valid && !out_stall) begin
        if (expected_signals.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected: id %0d value %h hit %b last %b",
                                    out_signal_id, out_signal_value, out_hit, out_last));
        end else begin
          want = expected_signals.pop_front();
          if (out_signal_id !== want.sig_id)
            report_mismatch($sformatf("signal_id %0d, expected %0d", out_signal_id, want.sig_id));
          if (out_signal_value !== want.value)
            report_mismatch($sformatf("signal_value %h, expected %h", out_signal_value, want.value));
          if (out_hit !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", out_hit, want.hit));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
        end
      end
      // Input side: descriptor beats update the table, frame beats give results.
      if (in_valid && !in_stall) begin
        if (in_action == ACT_WRITE) begin
          d = '0;
          if (in_slot_valid) begin
            d.valid   = 1'b1;
            d.can_id  = in_frame_id;
            d.sig_num = in_signal_number;
            d.byte_hi = in_byte_high;
            d.byte_lo = in_byte_low;
            d.bit_hi  = in_bit_high;
            d.bit_lo  = in_bit_low;
          end
          slot_table[in_slot] = d;
        end else begin
          predict_frame(in_frame_id, in_frame_data);
        end
      end
    end
    pending_results <= expected_signals.size();
  end

endmodule

### tb/can_frame_signal_extractor_core_test.sv
// Stimulus, flow control and verdict for the CAN signal extractor core.
module can_frame_signal_extractor_core_test;
  import cfse_pkg::*;

  localparam int RANDOM_ITEMS    = 120;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int RUN_LIMIT       = 400000;
  localparam logic [28:0] ID_MAX = 29'h1FFFFFFF;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [3:0]  in_slot;
  logic        in_slot_valid;
  logic [3:0]  in_signal_number;
  logic [28:0] in_frame_id;
  logic [2:0]  in_byte_high;
  logic [2:0]  in_byte_low;
  logic [2:0]  in_bit_high;
  logic [2:0]  in_bit_low;
  logic [63:0] in_frame_data;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_signal_id;
  logic [31:0] out_signal_value;
  logic        out_hit;
  logic        out_last;
  int          mismatches;
  int          pending_results;

  logic        hold_off_req = 1'b0;
  int          burst_left = 0;
  logic [28:0] id_pool [4];

  always #1 clk = ~clk;

  can_frame_signal_extractor_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_slot          (in_slot),
    .in_slot_valid    (in_slot_valid),
    .in_signal_number (in_signal_number),
    .in_frame_id      (in_frame_id),
    .in_byte_high     (in_byte_high),
    .in_byte_low      (in_byte_low),
    .in_bit_high      (in_bit_high),
    .in_bit_low       (in_bit_low),
    .in_frame_data    (in_frame_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_signal_id    (out_signal_id),
    .out_signal_value (out_signal_value),
    .out_hit          (out_hit),
    .out_last         (out_last)
  );

  can_frame_signal_extractor_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_slot          (in_slot),
    .in_slot_valid    (in_slot_valid),
    .in_signal_number (in_signal_number),
    .in_frame_id      (in_frame_id),
    .in_byte_high     (in_byte_high),
    .in_byte_low      (in_byte_low),
    .in_bit_high      (in_bit_high),
    .in_bit_low       (in_bit_low),
    .in_frame_data    (in_frame_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_signal_id    (out_signal_id),
    .out_signal_value (out_signal_value),
    .out_hit          (out_hit),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .pending_results  (pending_results)
  );

  // Offer one input beat, inserting a random gap between bursts, and wait
  // until it is accepted.
  task automatic offer_beat(logic action, logic [3:0] slot, logic slot_valid,
                            logic [3:0] sig, logic [28:0] id, logic [2:0] bh,
                            logic [2:0] bl, logic [2:0] bith, logic [2:0] bitl,
                            logic [63:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_action        <= action;
    in_slot          <= slot;
    in_slot_valid    <= slot_valid;
    in_signal_number <= sig;
    in_frame_id      <= id;
    in_byte_high     <= bh;
    in_byte_low      <= bl;
    in_bit_high      <= bith;
    in_bit_low       <= bitl;
    in_frame_data    <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Descriptor beat; the data bytes are ignored by the block, so they are random.
  task automatic write_slot(logic [3:0] slot, logic slot_valid, logic [3:0] sig,
                            logic [28:0] id, logic [2:0] bh, logic [2:0] bl,
                            logic [2:0] bith, logic [2:0] bitl);
    offer_beat(ACT_WRITE, slot, slot_valid, sig, id, bh, bl, bith, bitl,
               {$urandom, $urandom});
  endtask

  // Frame beat; the descriptor-only fields are ignored, so they are random.
  task automatic present_frame(logic [28:0] id, logic [63:0] data);
    offer_beat(ACT_FRAME, 4'($urandom), 1'($urandom), 4'($urandom), id,
               3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom), data);
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_results != 0 && guard < DRAIN_LIMIT);
  endtask

  // Receiver flow control: random stall patterns, plus one long hold-off on request.
  initial begin : receiver
    int mode;
    int len;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(1, 40);
        for (int k = 0; k < len && !hold_off_req; k++) begin
          out_stall <= (mode == 0) ? 1'b0 :
                       (mode == 1) ? ($urandom_range(0, 1) == 1) :
                                     ($urandom_range(0, 9) < 8);
          @(posedge clk);
        end
      end
    end
  end

  // Run-time limit.
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("[can_frame_signal_extractor_core] ERROR");
    $finish;
  end

  // Reset, directed beats, random beats, drain and verdict.
  initial begin : stimulus
    logic [28:0] id;
    int          shape;
    int          hi;
    int          lo;
    int          bh_bit;
    int          bl_bit;

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_action        <= ACT_WRITE;
    in_slot          <= '0;
    in_slot_valid    <= 1'b0;
    in_signal_number <= '0;
    in_frame_id      <= '0;
    in_byte_high     <= '0;
    in_byte_low      <= '0;
    in_bit_high      <= '0;
    in_bit_low       <= '0;
    in_frame_data    <= '0;
    id_pool[0] = ID_MAX;
    for (int i = 1; i < 4; i++) begin
      id_pool[i] = 29'($urandom);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A frame against the empty table finds no match.
    present_frame(29'h0, {$urandom, $urandom});

    // Fill every slot with the same identifier, one field layout per slot.
    write_slot(4'd0,  1'b1, 4'd3,  ID_MAX, 3'd3, 3'd0, 3'd0, 3'd0);  // four bytes
    write_slot(4'd1,  1'b1, 4'd15, ID_MAX, 3'd7, 3'd6, 3'd5, 3'd2);  // two top bytes
    write_slot(4'd2,  1'b1, 4'd7,  ID_MAX, 3'd5, 3'd5, 3'd0, 3'd0);  // whole byte
    write_slot(4'd3,  1'b1, 4'd1,  ID_MAX, 3'd2, 3'd2, 3'd6, 3'd2);  // bit field
    write_slot(4'd4,  1'b1, 4'd2,  ID_MAX, 3'd1, 3'd1, 3'd2, 3'd5);  // reversed bits
    write_slot(4'd5,  1'b1, 4'd4,  ID_MAX, 3'd2, 3'd4, 3'd0, 3'd0);  // reversed bytes
    write_slot(4'd6,  1'b1, 4'd5,  ID_MAX, 3'd6, 3'd1, 3'd0, 3'd0);  // too wide
    write_slot(4'd7,  1'b1, 4'd6,  ID_MAX, 3'd7, 3'd7, 3'd7, 3'd7);  // top bit only
    write_slot(4'd8,  1'b1, 4'd8,  ID_MAX, 3'd1, 3'd0, 3'd3, 3'd3);
    write_slot(4'd9,  1'b1, 4'd9,  ID_MAX, 3'd2, 3'd0, 3'd0, 3'd0);
    write_slot(4'd10, 1'b1, 4'd10, ID_MAX, 3'd7, 3'd7, 3'd7, 3'd0);  // full-width field
    write_slot(4'd11, 1'b1, 4'd11, ID_MAX, 3'd0, 3'd0, 3'd0, 3'd0);
    write_slot(4'd12, 1'b1, 4'd12, ID_MAX, 3'd3, 3'd3, 3'd3, 3'd3);
    write_slot(4'd13, 1'b1, 4'd13, ID_MAX, 3'd7, 3'd4, 3'd7, 3'd7);
    write_slot(4'd14, 1'b1, 4'd14, ID_MAX, 3'd7, 3'd3, 3'd1, 3'd1);
    write_slot(4'd15, 1'b1, 4'd0,  ID_MAX, 3'd4, 3'd4, 3'd1, 3'd0);

    // Every slot matches, so the scan is capped at the result limit.
    present_frame(ID_MAX, '1);
    present_frame(ID_MAX, '0);
    present_frame(ID_MAX, {$urandom, $urandom});

    // Clearing a slot drops its match; cleared slots hold id zero but stay invalid.
    write_slot(4'd15, 1'b0, 4'd15, ID_MAX, 3'd7, 3'd7, 3'd7, 3'd7);
    present_frame(ID_MAX, {$urandom, $urandom});
    present_frame(29'h0, {$urandom, $urandom});

    // Random beats, mostly descriptors and frames that share a small id pool.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 40) begin
        hold_off_req = 1'b1;
        burst_left = 30;
      end
      if (n == 80) wait_drained();
      if ($urandom_range(0, 15) == 0) id_pool[$urandom_range(0, 3)] = 29'($urandom);
      if ($urandom_range(0, 99) < 35) begin
        shape  = $urandom_range(0, 3);
        lo     = $urandom_range(0, 7);
        hi     = $urandom_range(0, 7);
        bh_bit = $urandom_range(0, 7);
        bl_bit = $urandom_range(0, 7);
        case (shape)
          0: begin
            // Joined bytes of a legal width.
            lo = $urandom_range(0, 6);
            hi = $urandom_range(lo + 1, (lo + 3 > 7) ? 7 : lo + 3);
          end
          1: begin
            // Whole byte.
            hi     = lo;
            bh_bit = 0;
            bl_bit = 0;
          end
          2: begin
            // Well-formed bit field.
            hi     = lo;
            bh_bit = $urandom_range(bl_bit, 7);
          end
          default: begin
          end
        endcase
        id = ($urandom_range(0, 9) == 0) ? 29'($urandom) : id_pool[$urandom_range(0, 3)];
        write_slot(4'($urandom), ($urandom_range(0, 99) < 85), 4'($urandom), id,
                   3'(hi), 3'(lo), 3'(bh_bit), 3'(bl_bit));
      end else begin
        id = ($urandom_range(0, 4) == 0) ? 29'($urandom) : id_pool[$urandom_range(0, 3)];
        present_frame(id, {$urandom, $urandom});
      end
    end

    wait_drained();
    repeat (SLOT_COUNT_DEF + 8) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("[can_frame_signal_extractor_core] OK");
    end else begin
      if (pending_results != 0) $display("%0d expected results never arrived", pending_results);
      $display("[can_frame_signal_extractor_core] ERROR");
    end
    $finish;
  end

endmodule
